// ===== rtl/lsdmc_pkg.sv =====
// Package for the multi-size LRU miss counter.
// Holds item structs, register indexes and fixed widths; depends on nothing.
package lsdmc_pkg;

  localparam int ADDR_W     = 24;
  localparam int SIZE_W     = 9;
  localparam int COUNT_W    = 32;
  localparam int SIDX_W     = 2;
  localparam int REG_COUNT  = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;
  localparam int K_W        = 3;

  localparam logic OP_ACCESS = 1'b0;
  localparam logic OP_REPORT = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_SIZES_IN_USE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_A       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_B       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_C       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_D       = 3'd4;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic              op;
    logic [ADDR_W-1:0] address;
  } in_item_t;

  typedef struct packed {
    logic [SIDX_W-1:0]  size_index;
    logic [COUNT_W-1:0] miss_count;
    logic               last;
  } out_item_t;

endpackage

// ===== rtl/lsdmc_cell.sv =====
// One entry of the LRU recency stack, with its own address compare.
// Used by lsdmc_chain; needs no package items.
module lsdmc_cell #(
  parameter int INDEX = 0,
  parameter int AW    = 24,
  parameter int PW    = 8,
  parameter int FW    = 9
) (
  input  logic          clk,
  input  logic          cmp,
  input  logic          upd,
  input  logic          found,
  input  logic [PW-1:0] pos,
  input  logic [FW-1:0] fill,
  input  logic [AW-1:0] key,
  input  logic [AW-1:0] prev,
  output logic [AW-1:0] entry,
  output logic          match
);

  logic live;
  logic shift_en;

  assign live     = FW'(INDEX) < fill;
  // Cells from the top down to the hit position move one place deeper;
  // on a miss every cell moves and the bottom entry falls off.
  assign shift_en = !found || (PW'(INDEX) <= pos);

  always_ff @(posedge clk) begin
    if (cmp) begin
      match <= live && (entry == key);
    end
    if (upd && shift_en) begin
      entry <= prev;
    end
  end

endmodule

// ===== rtl/lsdmc_chain.sv =====
// Row of recency stack cells, the fill count and the hit position encoder.
// Instantiates lsdmc_cell; needs no package items.
module lsdmc_chain #(
  parameter int DEPTH = 256,
  parameter int AW    = 24,
  parameter int PW    = 8,
  parameter int FW    = 9
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmp,
  input  logic          upd,
  input  logic [AW-1:0] key,
  output logic          found,
  output logic [PW-1:0] pos
);

  logic [FW-1:0]    fill;
  logic [AW-1:0]    entries [DEPTH];
  logic [DEPTH-1:0] match;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [AW-1:0] prev;
    if (g == 0) begin : g_top
      assign prev = key;
    end else begin : g_rest
      assign prev = entries[g-1];
    end
    lsdmc_cell #(
      .INDEX(g),
      .AW   (AW),
      .PW   (PW),
      .FW   (FW)
    ) u_cell (
      .clk  (clk),
      .cmp  (cmp),
      .upd  (upd),
      .found(found),
      .pos  (pos),
      .fill (fill),
      .key  (key),
      .prev (prev),
      .entry(entries[g]),
      .match(match[g])
    );
  end

  // Addresses in the stack are unique, so at most one match bit is set.
  always_comb begin
    pos = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (match[i]) begin
        pos = pos | PW'(i);
      end
    end
  end

  assign found = |match;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (upd && !found && (fill != FW'(DEPTH))) begin
      fill <= fill + 1'b1;
    end
  end

endmodule

// ===== rtl/lru_stack_distance_miss_counter.sv =====
// Multi-size LRU miss counter: one recency stack simulates several fully
// associative LRU caches at once.
// in_item (op, address) comes in on in_valid / in_stall. An access yields no
// result: it compares the address against every stack cell in the compare
// state and updates the counters and moves the stack in the next; input
// stalls in the compare state; the next item is accepted on the update cycle.
// A report yields one out_item per active size (size_index, miss_count,
// last on the final one) on out_valid / out_stall, one per cycle while the
// receiver does not stall, starting once the report state has loaded the
// output register, and then clears all counters.
// With no active sizes a report gives no item and still clears the counters.
// The output register holds an item while out_stall is high; the block keeps
// taking input items meanwhile until the report loop needs that register.
// Configuration is written on cfg_valid / cfg_ready (always ready) by
// register index. Synchronous reset empties the stack, clears the counters
// and loads sizes_in_use = 4 and sizes 1, 4, 16, 64.
// Counters hold at their maximum rather than wrap.
module lru_stack_distance_miss_counter #(
  parameter int STACK_DEPTH = 256,
  parameter int NUM_SIZES   = 4,
  parameter int ADDR_BITS   = 24
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  lsdmc_pkg::in_item_t                 in_item,
  output logic                                out_valid,
  input  logic                                out_stall,
  output lsdmc_pkg::out_item_t                out_item,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lsdmc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lsdmc_pkg::CFG_DATA_W-1:0]    cfg_data
);

  import lsdmc_pkg::*;

  localparam int PW     = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int FW     = $clog2(STACK_DEPTH + 1);
  localparam int CNT_N  = (NUM_SIZES < REG_COUNT) ? NUM_SIZES : REG_COUNT;
  localparam int CNT_IW = (CNT_N > 1) ? $clog2(CNT_N) : 1;
  localparam int CMPW   = (PW > SIZE_W) ? PW : SIZE_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CMP  = 2'd1;
  localparam logic [1:0] ST_UPD  = 2'd2;
  localparam logic [1:0] ST_RPT  = 2'd3;

  logic [1:0]           state;
  logic [ADDR_BITS-1:0] key;
  logic [K_W-1:0]       sizes_in_use;
  logic [SIZE_W-1:0]    size_reg [REG_COUNT];
  logic [COUNT_W-1:0]   cnt [CNT_N];
  logic [SIDX_W-1:0]    rpt_idx;

  logic          accept;
  logic          found;
  logic [PW-1:0] pos;
  logic [K_W-1:0] k;
  logic [CNT_N-1:0] inc;
  logic          slot_free;
  logic          rpt_last;

  assign in_stall  = !((state == ST_IDLE) || (state == ST_UPD));
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign k = (sizes_in_use > K_W'(CNT_N)) ? K_W'(CNT_N) : sizes_in_use;

  lsdmc_chain #(
    .DEPTH(STACK_DEPTH),
    .AW   (ADDR_BITS),
    .PW   (PW),
    .FW   (FW)
  ) u_chain (
    .clk  (clk),
    .rst  (rst),
    .cmp  (state == ST_CMP),
    .upd  (state == ST_UPD),
    .key  (key),
    .found(found),
    .pos  (pos)
  );

  // A size is bumped while the distance exceeds it; the first size that
  // holds the address stops the walk for all larger indexes.
  always_comb begin
    logic stop;
    stop = 1'b0;
    for (int i = 0; i < CNT_N; i++) begin
      if (found && (CMPW'(pos) < CMPW'(size_reg[i]))) begin
        stop = 1'b1;
      end
      inc[i] = !stop && (K_W'(i) < k);
    end
  end

  assign slot_free = !out_valid || !out_stall;
  assign rpt_last  = (K_W'(rpt_idx) + 1'b1) == k;

  always_ff @(posedge clk) begin
    if (accept) begin
      key <= ADDR_BITS'(in_item.address);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rpt_idx   <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < CNT_N; i++) begin
        cnt[i] <= '0;
      end
    end else begin
      // The report loop refills the output register whenever it frees up.
      if (slot_free && !((state == ST_RPT) && (k != '0))) begin
        out_valid <= 1'b0;
      end
      if (state == ST_UPD) begin
        for (int i = 0; i < CNT_N; i++) begin
          if (inc[i] && (cnt[i] != COUNT_MAX)) begin
            cnt[i] <= cnt[i] + 1'b1;
          end
        end
      end
      case (state)
        ST_IDLE, ST_UPD: begin
          if (accept) begin
            rpt_idx <= '0;
            state   <= (in_item.op == OP_REPORT) ? ST_RPT : ST_CMP;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_CMP: begin
          state <= ST_UPD;
        end
        ST_RPT: begin
          if (k == '0) begin
            for (int i = 0; i < CNT_N; i++) begin
              cnt[i] <= '0;
            end
            state <= ST_IDLE;
          end else if (slot_free) begin
            out_valid           <= 1'b1;
            out_item.size_index <= rpt_idx;
            out_item.miss_count <= cnt[CNT_IW'(rpt_idx)];
            out_item.last       <= rpt_last;
            if (rpt_last) begin
              for (int i = 0; i < CNT_N; i++) begin
                cnt[i] <= '0;
              end
              state <= ST_IDLE;
            end else begin
              rpt_idx <= rpt_idx + 1'b1;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sizes_in_use <= K_W'(4);
      size_reg[0]  <= SIZE_W'(1);
      size_reg[1]  <= SIZE_W'(4);
      size_reg[2]  <= SIZE_W'(16);
      size_reg[3]  <= SIZE_W'(64);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SIZES_IN_USE: sizes_in_use <= cfg_data[K_W-1:0];
        REG_SIZE_A:       size_reg[0]  <= cfg_data[SIZE_W-1:0];
        REG_SIZE_B:       size_reg[1]  <= cfg_data[SIZE_W-1:0];
        REG_SIZE_C:       size_reg[2]  <= cfg_data[SIZE_W-1:0];
        REG_SIZE_D:       size_reg[3]  <= cfg_data[SIZE_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule
